FILE: design/bsc_pkg.sv
// Shared widths, codes, structures and helpers of the byte stream comparator.
`default_nettype none
package bsc_pkg;

   localparam int COUNT_BITS  = 48;
   localparam int INDEX_W     = 48;
   localparam int POS_W       = 49;
   localparam int OFFSET_W    = 32;
   localparam int LIMIT_W     = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int CMP_W       = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   typedef enum logic [1:0] {
      MODE_FIRST  = 2'd0,
      MODE_ALL    = 2'd1,
      MODE_STATUS = 2'd2,
      MODE_SILENT = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_LIMIT_ON   = 3'd1,
      CSR_BYTE_LIMIT = 3'd2,
      CSR_OFFSET_A   = 3'd3,
      CSR_OFFSET_B   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      RPT_LISTED       = 3'd0,
      RPT_FIRST_FINAL  = 3'd1,
      RPT_DIFF_SILENT  = 3'd2,
      RPT_IDENTICAL    = 3'd3,
      RPT_DIFFERED     = 3'd4,
      RPT_A_SHORT      = 3'd5,
      RPT_B_SHORT      = 3'd6,
      RPT_SHORT_SILENT = 3'd7
   } report_type;

   typedef struct packed {
      logic       start_req;
      logic       has_a;
      logic       has_b;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
   } item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] pair_count;
      logic [COUNT_BITS-1:0] newline_count;
      logic                  mismatch_seen;
      logic                  finished;
   } state_type;

   typedef struct packed {
      mode_type              mode;
      logic                  limit_on;
      logic [LIMIT_W-1:0]    byte_limit;
      logic [OFFSET_W-1:0]   offset_a;
      logic [OFFSET_W-1:0]   offset_b;
   } cfg_type;

   typedef struct packed {
      report_type          report;
      logic                is_final;
      logic [INDEX_W-1:0]  byte_index;
      logic [INDEX_W-1:0]  line_no;
      logic [POS_W-1:0]    position_a;
      logic [POS_W-1:0]    position_b;
      logic [7:0]          value_a;
      logic [7:0]          value_b;
   } result_type;

   // Increment that sticks at the all-ones value.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (&v) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/byte_stream_comparator.sv
// Top level of the byte stream comparator: handshakes, registers and configuration.
`default_nettype none
// The comparator takes one word per clock, each word holding a byte from stream A and
// a byte from stream B with a presence flag for each and a start flag, and it sustains
// one word per cycle for as long as the result side does not stall. A word is
// captured in an input register, judged by short logic, once the result register is
// free or being emptied, against the running pair count, newline count and verdict
// flags, and any result is placed in an output register, from which it is offered.
// The input register and the output register let a new word be taken while a
// finished result still waits to be collected. Configuration registers should be
// written only while no word is in flight; they take effect on the next word judged.
// Counters saturate at their all-ones value, and after a final verdict words are
// swallowed without a result until one arrives with the start flag set.
module byte_stream_comparator (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_start_req,
   input  logic                             req_has_a,
   input  logic                             req_has_b,
   input  logic [7:0]                       req_byte_a,
   input  logic [7:0]                       req_byte_b,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_report,
   output logic                             rsp_is_final,
   output logic [bsc_pkg::INDEX_W-1:0]      rsp_byte_index,
   output logic [bsc_pkg::INDEX_W-1:0]      rsp_line_no,
   output logic [bsc_pkg::POS_W-1:0]        rsp_position_a,
   output logic [bsc_pkg::POS_W-1:0]        rsp_position_b,
   output logic [7:0]                       rsp_value_a,
   output logic [7:0]                       rsp_value_b,

   input  logic                             csr_write,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bsc_pkg::*;

   // Input register.
   logic       item_valid_ff, item_valid_in;
   item_type   item_ff, item_in;

   // Comparison state and configuration.
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       req_take;
   logic       process;
   logic       emit;
   result_type result;
   state_type  state_next;

   bsc_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .emit       (emit),
      .result     (result),
      .state_next (state_next)
   );

   // The held word is judged whenever the result register is free or being emptied.
   assign process   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !process;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = req_take || (item_valid_ff && !process);
      if (req_take) begin
         item_in.start_req = req_start_req;
         item_in.has_a     = req_has_a;
         item_in.has_b     = req_has_b;
         item_in.byte_a    = req_byte_a;
         item_in.byte_b    = req_byte_b;
      end else begin
         item_in = item_ff;
      end

      state_in = process ? state_next : state_ff;

      if (process) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
      rsp_in = (process && emit) ? result : rsp_ff;

      // Register writes; an index outside the register list is dropped.
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MODE:       cfg_in.mode       = mode_type'(csr_data[1:0]);
            CSR_LIMIT_ON:   cfg_in.limit_on   = csr_data[0];
            CSR_BYTE_LIMIT: cfg_in.byte_limit = csr_data[LIMIT_W-1:0];
            CSR_OFFSET_A:   cfg_in.offset_a   = csr_data[OFFSET_W-1:0];
            CSR_OFFSET_B:   cfg_in.offset_b   = csr_data[OFFSET_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
         cfg_ff        <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report      = rsp_ff.report;
   assign rsp_is_final    = rsp_ff.is_final;
   assign rsp_byte_index  = rsp_ff.byte_index;
   assign rsp_line_no     = rsp_ff.line_no;
   assign rsp_position_a  = rsp_ff.position_a;
   assign rsp_position_b  = rsp_ff.position_b;
   assign rsp_value_a     = rsp_ff.value_a;
   assign rsp_value_b     = rsp_ff.value_b;

   // A closed comparison swallows words without a start flag.
   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      (process && state_ff.finished && !item_ff.start_req) |=> !rsp_valid_ff)
      else $error("result produced after the final verdict");

   // A final result closes the comparison.
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      (process && emit && result.is_final) |=> state_ff.finished)
      else $error("final verdict did not close the comparison");

   // The pair count only moves forward within a comparison.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (process && !item_ff.start_req) |=> (state_ff.pair_count >= $past(state_ff.pair_count)))
      else $error("pair count went backwards");

   // A new result only comes from a judged word.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(process))
      else $error("result appeared without a judged word");

endmodule
`default_nettype wire

FILE: design/bsc_step.sv
// Decision logic for one byte pair: result word and next comparison state.
`default_nettype none
module bsc_step (
   input  bsc_pkg::item_type   item,
   input  bsc_pkg::state_type  state,
   input  bsc_pkg::cfg_type    cfg,
   output logic                emit,
   output bsc_pkg::result_type result,
   output bsc_pkg::state_type  state_next
);
   import bsc_pkg::*;

   state_type             cur;
   logic                  limit_hit;
   logic                  bytes_differ;
   logic [COUNT_BITS-1:0] nl_bumped;
   logic [INDEX_W-1:0]    idx;

   always_comb begin
      // A start request clears everything before the pair is looked at.
      if (item.start_req) begin
         cur = '0;
      end else begin
         cur = state;
      end

      limit_hit    = cfg.limit_on &&
                     (CMP_W'(cur.pair_count) >= CMP_W'(cfg.byte_limit));
      bytes_differ = (item.byte_a != item.byte_b);
      nl_bumped    = (item.byte_a == NEWLINE_BYTE) ? sat_inc(cur.newline_count)
                                                   : cur.newline_count;

      idx                = INDEX_W'(cur.pair_count);
      result.byte_index  = idx;
      result.line_no     = INDEX_W'(sat_inc(cur.newline_count));
      result.position_a  = POS_W'(idx) + POS_W'(cfg.offset_a);
      result.position_b  = POS_W'(idx) + POS_W'(cfg.offset_b);
      result.report      = RPT_IDENTICAL;
      result.is_final    = 1'b1;
      result.value_a     = '0;
      result.value_b     = '0;

      emit       = 1'b0;
      state_next = cur;

      if (cur.finished) begin
         emit = 1'b0;
      end else if (limit_hit || (!item.has_a && !item.has_b)) begin
         emit                = 1'b1;
         result.report       = cur.mismatch_seen ? RPT_DIFFERED : RPT_IDENTICAL;
         state_next.finished = 1'b1;
      end else if (!item.has_a || !item.has_b) begin
         emit = 1'b1;
         if (cfg.mode == MODE_STATUS) begin
            result.report = RPT_SHORT_SILENT;
         end else if (!item.has_a) begin
            result.report = RPT_A_SHORT;
         end else begin
            result.report = RPT_B_SHORT;
         end
         state_next.finished = 1'b1;
      end else if (bytes_differ) begin
         emit           = 1'b1;
         result.value_a = item.byte_a;
         result.value_b = item.byte_b;
         case (cfg.mode)
            MODE_ALL: begin
               result.report            = RPT_LISTED;
               result.is_final          = 1'b0;
               state_next.mismatch_seen = 1'b1;
               state_next.newline_count = nl_bumped;
               state_next.pair_count    = sat_inc(cur.pair_count);
            end
            MODE_FIRST: begin
               result.report       = RPT_FIRST_FINAL;
               state_next.finished = 1'b1;
            end
            default: begin
               result.report       = RPT_DIFF_SILENT;
               state_next.finished = 1'b1;
            end
         endcase
      end else begin
         state_next.newline_count = nl_bumped;
         state_next.pair_count    = sat_inc(cur.pair_count);
      end
   end

endmodule
`default_nettype wire

FILE: verif/byte_stream_comparator_tb.sv
// Self-checking testbench for the byte stream comparator: directed table, pressure and random phases.
module byte_stream_comparator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   // An index that no register answers to; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int WORD_BITS = $bits(item_type);
   localparam int MAX_REPORTS = 10;

   // One row of the directed table. When reconfig is set, the next entry of the
   // settings table is applied before the word is sent. When typed is set, the
   // report code is taken from the table rather than from the predictor.
   typedef struct packed {
      logic       reconfig;
      item_type   w;
      logic       typed;
      report_type rpt;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;

   logic             req_valid     = 1'b0;
   logic             req_stall;
   logic             req_start_req = 1'b0;
   logic             req_has_a     = 1'b0;
   logic             req_has_b     = 1'b0;
   logic [7:0]       req_byte_a    = 8'h00;
   logic [7:0]       req_byte_b    = 8'h00;

   logic             rsp_valid;
   logic             rsp_stall;
   logic [2:0]       rsp_report;
   logic             rsp_is_final;
   logic [INDEX_W-1:0] rsp_byte_index;
   logic [INDEX_W-1:0] rsp_line_no;
   logic [POS_W-1:0] rsp_position_a;
   logic [POS_W-1:0] rsp_position_b;
   logic [7:0]       rsp_value_a;
   logic [7:0]       rsp_value_b;

   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // The result side stalls either for its own per-word pause or for the long
   // hold that forces the comparator to fill up and push back on its input.
   logic rx_pause  = 1'b0;
   logic long_hold = 1'b0;
   assign rsp_stall = rx_pause | long_hold;

   // calm switches idling off on both sides; squeeze makes the sender go flat out.
   bit calm    = 1'b0;
   bit squeeze = 1'b0;

   // Tag of the word currently on the input bus, read when it is accepted.
   bit         tag_typed  = 1'b0;
   report_type tag_report = RPT_LISTED;

   // Predictor state: a private copy of the registers and the comparison state.
   cfg_type               live_cfg      = '0;
   logic [COUNT_BITS-1:0] pairs_seen    = '0;
   logic [COUNT_BITS-1:0] newlines_seen = '0;
   bit                    listed_diff   = 1'b0;
   bit                    verdict_given = 1'b0;

   result_type awaited_reports[$];
   int         faults     = 0;
   int         live_words = 0;

   // Settings walked by the directed table, one per row with reconfig set. The
   // first rows of the table run with the register values left by reset.
   cfg_type directed_settings [6] = '{
      '{MODE_ALL,    1'b1, 48'd3,              32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{MODE_STATUS, 1'b0, 48'd3,              32'h0000_0000, 32'hFFFF_FFFF},
      '{MODE_SILENT, 1'b1, 48'd0,              32'h1234_5678, 32'h0000_0000},
      '{MODE_FIRST,  1'b0, 48'd0,              32'h0000_0000, 32'h0000_0000},
      '{MODE_SILENT, 1'b0, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
      '{MODE_ALL,    1'b1, 48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000}
   };

   plan_row_type directed_plan [24] = '{
      // Reset settings: first difference, no limit, zero offsets.
      '{1'b0, '{1'b1, 1'b1, 1'b1, 8'h00, 8'h00}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h0A, 8'h0A}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'hFF, 8'h00}, 1'b1, RPT_FIRST_FINAL},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h12, 8'h34}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, RPT_IDENTICAL},
      // All differences with a limit of three pairs and the largest offsets.
      '{1'b1, '{1'b1, 1'b1, 1'b1, 8'h0A, 8'h0B}, 1'b1, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h00, 8'hFF}, 1'b1, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h41, 8'h41}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h7E, 8'h7E}, 1'b1, RPT_DIFFERED},
      // Status only: short streams are reported without naming the side.
      '{1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 8'h80}, 1'b1, RPT_SHORT_SILENT},
      '{1'b0, '{1'b1, 1'b1, 1'b1, 8'h55, 8'hAA}, 1'b1, RPT_DIFF_SILENT},
      '{1'b0, '{1'b1, 1'b1, 1'b1, 8'h10, 8'h10}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b0, 8'h01, 8'h00}, 1'b1, RPT_SHORT_SILENT},
      // A limit of zero closes the comparison on its very first pair.
      '{1'b1, '{1'b1, 1'b1, 1'b1, 8'hC3, 8'h3C}, 1'b1, RPT_IDENTICAL},
      '{1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 8'h00}, 1'b1, RPT_A_SHORT},
      '{1'b0, '{1'b1, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b1, RPT_B_SHORT},
      '{1'b1, '{1'b1, 1'b1, 1'b1, 8'h01, 8'h02}, 1'b1, RPT_DIFF_SILENT},
      '{1'b0, '{1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF}, 1'b1, RPT_IDENTICAL},
      // All differences, largest limit; the last word falls after the verdict.
      '{1'b1, '{1'b1, 1'b1, 1'b1, 8'h0A, 8'h0A}, 1'b0, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h0A, 8'h0B}, 1'b1, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'hFF, 8'hFE}, 1'b1, RPT_LISTED},
      '{1'b0, '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, RPT_DIFFERED},
      '{1'b0, '{1'b0, 1'b1, 1'b1, 8'h00, 8'h00}, 1'b0, RPT_LISTED}
   };

   byte_stream_comparator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_req   (req_start_req),
      .req_has_a       (req_has_a),
      .req_has_b       (req_has_b),
      .req_byte_a      (req_byte_a),
      .req_byte_b      (req_byte_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_report      (rsp_report),
      .rsp_is_final    (rsp_is_final),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_line_no     (rsp_line_no),
      .rsp_position_a  (rsp_position_a),
      .rsp_position_b  (rsp_position_b),
      .rsp_value_a     (rsp_value_a),
      .rsp_value_b     (rsp_value_b),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A counter that sticks once it reaches all ones.
   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] n);
      return (n == '1) ? n : n + COUNT_BITS'(1);
   endfunction

   // Builds a report from the current pair and newline counts.
   function automatic result_type verdict(input report_type code, input logic fin,
                                          input logic [7:0] va, input logic [7:0] vb);
      result_type r;
      r.report      = code;
      r.is_final    = fin;
      r.byte_index  = pairs_seen;
      r.line_no     = bump(newlines_seen);
      r.position_a  = POS_W'(pairs_seen) + POS_W'(live_cfg.offset_a);
      r.position_b  = POS_W'(pairs_seen) + POS_W'(live_cfg.offset_b);
      r.value_a     = va;
      r.value_b     = vb;
      return r;
   endfunction

   // Counts a compared pair, and a newline when stream A carries one.
   function automatic void advance(input logic [7:0] a);
      if (a == NEWLINE_BYTE) begin
         newlines_seen = bump(newlines_seen);
      end
      pairs_seen = bump(pairs_seen);
   endfunction

   // Judges one accepted word against the predictor state. Returns 1 and fills
   // in the report when the word produces one.
   function automatic bit judge_word(input item_type w, output result_type r);
      report_type code;
      if (w.start_req) begin
         pairs_seen    = '0;
         newlines_seen = '0;
         listed_diff   = 1'b0;
         verdict_given = 1'b0;
      end
      if (verdict_given) begin
         return 1'b0;
      end
      live_words++;
      // The byte limit is tested before either stream is looked at.
      if ((live_cfg.limit_on && pairs_seen >= live_cfg.byte_limit) ||
          (!w.has_a && !w.has_b)) begin
         code = listed_diff ? RPT_DIFFERED : RPT_IDENTICAL;
         r = verdict(code, 1'b1, 8'h00, 8'h00);
         verdict_given = 1'b1;
         return 1'b1;
      end
      if (!w.has_a || !w.has_b) begin
         if (live_cfg.mode == MODE_STATUS) begin
            code = RPT_SHORT_SILENT;
         end else if (!w.has_a) begin
            code = RPT_A_SHORT;
         end else begin
            code = RPT_B_SHORT;
         end
         r = verdict(code, 1'b1, 8'h00, 8'h00);
         verdict_given = 1'b1;
         return 1'b1;
      end
      if (w.byte_a != w.byte_b) begin
         if (live_cfg.mode == MODE_ALL) begin
            // Listed mismatch: reported against the counts before this pair.
            r = verdict(RPT_LISTED, 1'b0, w.byte_a, w.byte_b);
            listed_diff = 1'b1;
            advance(w.byte_a);
            return 1'b1;
         end
         code = (live_cfg.mode == MODE_FIRST) ? RPT_FIRST_FINAL : RPT_DIFF_SILENT;
         r = verdict(code, 1'b1, w.byte_a, w.byte_b);
         verdict_given = 1'b1;
         return 1'b1;
      end
      advance(w.byte_a);
      return 1'b0;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("report=%0d final=%0b index=%0d line=%0d pos_a=%0d pos_b=%0d a=%02h b=%02h",
                       r.report, r.is_final, r.byte_index, r.line_no,
                       r.position_a, r.position_b, r.value_a, r.value_b);
   endfunction

   // Scoreboard. Results are checked first, then the accepted word (if any) is
   // judged; a word's report always leaves the block on a later edge.
   always @(posedge clock) begin : scoreboard
      result_type seen;
      result_type want;
      item_type   w;
      bit         produced;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.report      = report_type'(rsp_report);
            seen.is_final    = rsp_is_final;
            seen.byte_index  = rsp_byte_index;
            seen.line_no     = rsp_line_no;
            seen.position_a  = rsp_position_a;
            seen.position_b  = rsp_position_b;
            seen.value_a     = rsp_value_a;
            seen.value_b     = rsp_value_b;
            if (awaited_reports.size() == 0) begin
               faults++;
               if (faults <= MAX_REPORTS) begin
                  $display("unexpected result: %s", describe(seen));
               end
            end else begin
               want = awaited_reports.pop_front();
               if (seen.report !== want.report || seen.is_final !== want.is_final ||
                   seen.byte_index !== want.byte_index ||
                   seen.line_no !== want.line_no ||
                   seen.position_a !== want.position_a ||
                   seen.position_b !== want.position_b ||
                   seen.value_a !== want.value_a || seen.value_b !== want.value_b) begin
                  faults++;
                  if (faults <= MAX_REPORTS) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %s", describe(want));
                     $display("  actual   %s", describe(seen));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            w = {req_start_req, req_has_a, req_has_b, req_byte_a, req_byte_b};
            want = '0;
            produced = judge_word(w, want);
            // Rows of the directed table fix the report code by hand.
            if (tag_typed) begin
               want.report   = tag_report;
               want.is_final = (tag_report != RPT_LISTED);
               produced      = 1'b1;
            end
            if (produced) begin
               awaited_reports.push_back(want);
            end
         end
      end
   end

   // Result side: before each word it collects, it pauses for a drawn number of
   // cycles, then takes the next result as soon as one is offered.
   initial begin : result_sink
      int unsigned pause;
      forever begin
         pause = calm ? 0 : $urandom_range(13, 0);
         repeat (pause) begin
            @(negedge clock);
            rx_pause <= 1'b1;
         end
         @(negedge clock);
         rx_pause <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // The long hold: once the pressure phase begins, the result side refuses
   // everything for a long stretch while the sender keeps offering words.
   initial begin : backpressure
      wait (squeeze);
      repeat (120) begin
         @(negedge clock);
         long_hold <= 1'b1;
      end
      @(negedge clock);
      long_hold <= 1'b0;
   end

   // Offers one word after a drawn gap and waits until the block takes it.
   task automatic send_word(input item_type w, input bit typed, input report_type rpt);
      int unsigned gap;
      gap = (calm || squeeze) ? 0 : $urandom_range(13, 0);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      {req_start_req, req_has_a, req_has_b, req_byte_a, req_byte_b} <= w;
      tag_typed  = typed;
      tag_report = rpt;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drops valid and waits until every awaited report has arrived, then idles long
   // enough that words without a report have left the block.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes one register and keeps the predictor's copy in step with it.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_MODE:       live_cfg.mode       = mode_type'(val[1:0]);
         CSR_LIMIT_ON:   live_cfg.limit_on   = val[0];
         CSR_BYTE_LIMIT: live_cfg.byte_limit = val[LIMIT_W-1:0];
         CSR_OFFSET_A:   live_cfg.offset_a   = val[OFFSET_W-1:0];
         CSR_OFFSET_B:   live_cfg.offset_b   = val[OFFSET_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Brings the block to rest and writes every register, plus a stray write to
   // an index that does not exist.
   task automatic apply_settings(input cfg_type s);
      settle();
      write_reg(CSR_MODE,       CSR_DATA_W'(s.mode));
      write_reg(CSR_LIMIT_ON,   CSR_DATA_W'(s.limit_on));
      write_reg(CSR_BYTE_LIMIT, CSR_DATA_W'(s.byte_limit));
      write_reg(CSR_OFFSET_A,   CSR_DATA_W'(s.offset_a));
      write_reg(CSR_OFFSET_B,   CSR_DATA_W'(s.offset_b));
      write_reg(CSR_UNUSED,     CSR_DATA_W'({$urandom, $urandom}));
   endtask

   function automatic logic [OFFSET_W-1:0] pick_offset();
      case ($urandom_range(5, 0))
         0:       return '0;
         1:       return '1;
         default: return OFFSET_W'($urandom);
      endcase
   endfunction

   // One random comparison. Most are well formed: a start, a run of pairs that
   // mostly agree (with plenty of newlines), then an ending. The rest is noise.
   task automatic send_comparison();
      item_type    w;
      int unsigned run_len;
      int unsigned ending;
      int unsigned k;
      if ($urandom_range(6, 0) == 0) begin
         repeat ($urandom_range(4, 1)) begin
            w = WORD_BITS'($urandom);
            send_word(w, 1'b0, RPT_LISTED);
         end
         return;
      end
      run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 25) : $urandom_range(20, 0);
      for (k = 0; k <= run_len; k++) begin
         w.start_req = (k == 0);
         w.has_a     = 1'b1;
         w.has_b     = 1'b1;
         w.byte_a    = ($urandom_range(3, 0) == 0) ? NEWLINE_BYTE : 8'($urandom);
         w.byte_b    = ($urandom_range(14, 0) == 0) ? 8'($urandom) : w.byte_a;
         send_word(w, 1'b0, RPT_LISTED);
      end
      // Ending: both streams out, one of them out, or none (the next start cuts in).
      ending = $urandom_range(9, 0);
      if (ending < 8) begin
         w = WORD_BITS'($urandom);
         w.start_req = 1'b0;
         w.has_a     = (ending >= 6);
         w.has_b     = (ending >= 4 && ending < 6);
         send_word(w, 1'b0, RPT_LISTED);
      end
      if ($urandom_range(4, 0) == 0) begin
         w = WORD_BITS'($urandom);
         w.start_req = 1'b0;
         send_word(w, 1'b0, RPT_LISTED);
      end
   endtask

   initial begin : stimulus
      cfg_type     s;
      item_type    w;
      int unsigned next_setting;
      int unsigned phase;
      int unsigned k;
      int          mark;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. The first rows rely on the register values after reset.
      next_setting = 0;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].reconfig) begin
            apply_settings(directed_settings[next_setting]);
            next_setting++;
         end
         send_word(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].rpt);
      end

      // Pressure: every pair differs in all-differences mode, so each word
      // produces a report, while the result side holds off for a long time.
      s.mode       = MODE_ALL;
      s.limit_on   = 1'b0;
      s.byte_limit = '0;
      s.offset_a   = pick_offset();
      s.offset_b   = pick_offset();
      apply_settings(s);
      squeeze = 1'b1;
      for (k = 0; k < 40; k++) begin
         w.start_req = (k == 0);
         w.has_a     = 1'b1;
         w.has_b     = 1'b1;
         w.byte_a    = 8'($urandom);
         w.byte_b    = ~w.byte_a;
         send_word(w, 1'b0, RPT_LISTED);
      end
      squeeze = 1'b0;

      // Random phases, each under fresh settings; about a quarter of them run
      // without idling on either side.
      for (phase = 0; phase < 13; phase++) begin
         s.mode     = mode_type'($urandom_range(3, 0));
         s.limit_on = 1'($urandom_range(1, 0));
         case ($urandom_range(9, 0))
            0:       s.byte_limit = '0;
            1:       s.byte_limit = '1;
            default: s.byte_limit = LIMIT_W'($urandom_range(40, 0));
         endcase
         s.offset_a = pick_offset();
         s.offset_b = pick_offset();
         apply_settings(s);
         calm = ($urandom_range(3, 0) == 0);
         mark = live_words;
         while (live_words < mark + 100) send_comparison();
      end

      calm = 1'b0;
      settle();
      repeat (6) @(posedge clock);
      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog, set well beyond the slowest correct run.
   initial begin : watchdog
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/bsc_pkg.sv
design/bsc_step.sv
design/byte_stream_comparator.sv
verif/byte_stream_comparator_tb.sv
